// ===== hw/rtl/fchc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchc_pkg
// shared types and constants of the flow counter hash chain core
// ----------------------------------------------------------------------------
package fchc_pkg;

  localparam logic [7:0] RESET_PROTOCOL = 8'd6;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [15:0] len;
    logic [31:0] sum;
  } fchc_item_t;

  typedef struct packed {
    logic        new_flow;
    logic        status;
    logic [31:0] packets;
    logic [31:0] bytes;
  } fchc_result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCALE,
    ST_BREAD,
    ST_BCHECK,
    ST_PCHECK,
    ST_EMIT
  } fchc_state_t;

endpackage

// ===== hw/rtl/fchc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchc_front
// protocol filter, tuple packing and hash sum, feeding a two-entry queue
// ----------------------------------------------------------------------------
module fchc_front import fchc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [7:0]  protocol,
  input  logic [15:0] packet_length,
  output logic        item_valid,
  output fchc_item_t  item,
  input  logic        item_take
);

  logic [7:0] match_protocol;
  fchc_item_t q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       wr;
  logic       rd;

  assign full       = (count == 2'd2);
  assign wr         = push && !full && (protocol == match_protocol);
  assign item_valid = (count != 2'd0);
  assign rd         = item_valid && item_take;
  assign item       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      match_protocol <= RESET_PROTOCOL;
    end else if (cfg_we) begin
      match_protocol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr].src   <= source_address;
      q[wr_ptr].dst   <= dest_address;
      q[wr_ptr].ports <= {source_port, dest_port};
      q[wr_ptr].len   <= packet_length;
      q[wr_ptr].sum   <= source_address + dest_address
                         + {16'd0, source_port} + {16'd0, dest_port};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) (rd && !wr) |=> count == $past(count) - 2'd1)
    else $error("queue count after pop");

endmodule

// ===== hw/rtl/fchc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchc_back
// bucket lookup, overflow chain walk and counter update
// ----------------------------------------------------------------------------
module fchc_back import fchc_pkg::*; #(
  parameter int BUCKET_COUNT = 1021,
  parameter int POOL_ENTRIES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  fchc_item_t   item,
  output logic         item_take,
  output logic         res_valid,
  output fchc_result_t res,
  input  logic         res_take
);

  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam logic [31:0] BC = 32'(BUCKET_COUNT);
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKET_COUNT));
  localparam logic [BW-1:0] CLR_LAST = BW'(BUCKET_COUNT - 1);
  localparam logic [LW:0] PE = (LW + 1)'(POOL_ENTRIES);

  // entry word: {link, bytes, packets, ports, dst, src}
  localparam int EW = LW + 160;

  logic [EW-1:0] bmem [BUCKET_COUNT];
  logic [EW-1:0] pmem [POOL_ENTRIES];

  fchc_state_t   state, state_next;
  fchc_item_t    cur;
  fchc_result_t  outcome;
  logic [63:0]   prod;
  logic [31:0]   quot;
  logic [31:0]   scaled;
  logic [31:0]   rem;
  logic [31:0]   fold;
  logic [BW-1:0] bidx;
  logic [BW-1:0] clr;
  logic [PW-1:0] pidx;
  logic [EW-1:0] rdata;
  logic [LW-1:0] link;
  logic [LW-1:0] last;
  logic [LW:0]   steps;
  logic [LW:0]   pool_used;
  logic          out_full;
  logic          pending;

  logic [31:0]   e_src, e_dst, e_ports, e_pk, e_by;
  logic [LW-1:0] e_link;
  logic          hit, link_ok;

  assign e_src   = rdata[31:0];
  assign e_dst   = rdata[63:32];
  assign e_ports = rdata[95:64];
  assign e_pk    = rdata[127:96];
  assign e_by    = rdata[159:128];
  assign e_link  = rdata[EW-1:160];
  assign hit     = (e_src == cur.src) && (e_dst == cur.dst) && (e_ports == cur.ports);
  assign link_ok = (link != '0) && ({1'b0, link} <= PE) && (steps < PE);

  // reciprocal estimate is low by at most one, so one subtract finishes the modulo
  assign prod   = {32'd0, cur.sum} * {32'd0, RECIP};
  assign scaled = quot * BC;
  assign fold   = (rem >= BC) ? rem - BC : rem;

  assign item_take = (state == ST_IDLE) && item_valid;
  assign res_valid = out_full;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:   if (item_valid) state_next = ST_MOD;
      ST_MOD:    state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_BREAD;
      ST_BREAD:  state_next = ST_BCHECK;
      ST_BCHECK: begin
        if (e_pk == 32'd0 || hit) state_next = ST_EMIT;
        else state_next = ST_PCHECK;
      end
      ST_PCHECK: begin
        if (pending) begin
          if (hit) state_next = ST_EMIT;
        end else if (!link_ok) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT:   if (!out_full || res_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // chain walk: pchecks alternate between issuing the read of link and comparing it
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      pool_used <= '0;
      out_full  <= 1'b0;
      pending   <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= (state == ST_EMIT) || (out_full && !res_take);
      unique case (state)
        ST_CLEAR: begin
          bmem[clr] <= '0;
          clr       <= clr + 1'b1;
        end
        ST_IDLE: begin
          if (item_valid) cur <= item;
        end
        ST_MOD: begin
          quot <= prod[63:32];
        end
        ST_SCALE: begin
          rem <= cur.sum - scaled;
        end
        ST_BREAD: begin
          bidx  <= fold[BW-1:0];
          rdata <= bmem[fold[BW-1:0]];
        end
        ST_BCHECK: begin
          if (e_pk == 32'd0) begin
            bmem[bidx] <= {{LW{1'b0}}, {16'd0, cur.len}, 32'd1, cur.ports, cur.dst,
                           cur.src};
            outcome    <= '{new_flow: 1'b1, status: 1'b0, packets: 32'd1,
                            bytes: {16'd0, cur.len}};
          end else if (hit) begin
            bmem[bidx] <= {e_link, e_by + {16'd0, cur.len}, e_pk + 32'd1, e_ports,
                           e_dst, e_src};
            outcome    <= '{new_flow: 1'b0, status: 1'b0, packets: e_pk + 32'd1,
                            bytes: e_by + {16'd0, cur.len}};
          end else begin
            link    <= e_link;
            last    <= '0;
            steps   <= '0;
            pending <= 1'b0;
          end
        end
        ST_PCHECK: begin
          if (pending) begin
            pending <= 1'b0;
            if (hit) begin
              pmem[pidx] <= {e_link, e_by + {16'd0, cur.len}, e_pk + 32'd1, e_ports,
                             e_dst, e_src};
              outcome    <= '{new_flow: 1'b0, status: 1'b0, packets: e_pk + 32'd1,
                              bytes: e_by + {16'd0, cur.len}};
            end else begin
              last  <= link;
              link  <= e_link;
              steps <= steps + 1'b1;
            end
          end else if (link_ok) begin
            pidx    <= PW'(link - 1'b1);
            rdata   <= pmem[PW'(link - 1'b1)];
            pending <= 1'b1;
          end else begin
            if (pool_used >= PE) begin
              outcome <= '{new_flow: 1'b0, status: 1'b1, packets: 32'd0, bytes: 32'd0};
            end else begin
              pmem[PW'(pool_used)] <= {{LW{1'b0}}, {16'd0, cur.len}, 32'd1, cur.ports,
                                       cur.dst, cur.src};
              if (last == '0) begin
                bmem[bidx][EW-1:160] <= LW'(pool_used + 1'b1);
              end else begin
                pmem[PW'(last - 1'b1)][EW-1:160] <= LW'(pool_used + 1'b1);
              end
              pool_used <= pool_used + 1'b1;
              outcome   <= '{new_flow: 1'b1, status: 1'b0, packets: 32'd1,
                             bytes: {16'd0, cur.len}};
            end
          end
        end
        ST_EMIT: begin
          if (!out_full || res_take) res <= outcome;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) pool_used <= PE)
    else $error("pool count overflow");
  assert property (@(posedge clk) disable iff (rst) item_take |=> state == ST_MOD)
    else $error("item not started");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !out_full) |=> out_full)
    else $error("result not posted");

endmodule

// ===== hw/rtl/flow_counter_hash_chain_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_counter_hash_chain_core
// per-flow packet and byte counter with hashed buckets and overflow chains
// ----------------------------------------------------------------------------
// channel   handshake     payload
// input     push / full   source_address dest_address source_port dest_port
//                         protocol packet_length
// result    pop / empty   new_flow status flow_packets flow_bytes
// config    cfg_we        cfg_data (match_protocol)
//
// on a bucket hit or empty bucket a counted packet passes the back through take,
// two multiply steps of the modulo, bucket read, check and post,
// plus a read and a compare per entry walked, plus a last step if no entry matches
// packets of other protocols are dropped at the front and never reach the back
// after reset a clearing pass zeroes the buckets; only two counted beats are
// queued meanwhile
// the front queue holds two beats; posting waits while the result register is held
// ----------------------------------------------------------------------------
module flow_counter_hash_chain_core import fchc_pkg::*; #(
  parameter int BUCKET_COUNT = 1021,
  parameter int POOL_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [7:0]  protocol,
  input  logic [15:0] packet_length,
  output logic        empty,
  input  logic        pop,
  output logic        new_flow,
  output logic        status,
  output logic [31:0] flow_packets,
  output logic [31:0] flow_bytes
);

  logic         item_valid;
  logic         item_take;
  fchc_item_t   item;
  logic         res_valid;
  fchc_result_t res;

  fchc_front u_front (
    .clk, .rst, .cfg_we, .cfg_data, .push, .full,
    .source_address, .dest_address, .source_port, .dest_port,
    .protocol, .packet_length,
    .item_valid, .item, .item_take
  );

  fchc_back #(.BUCKET_COUNT(BUCKET_COUNT), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
    .clk, .rst, .item_valid, .item, .item_take,
    .res_valid, .res, .res_take(pop)
  );

  assign empty        = !res_valid;
  assign new_flow     = res.new_flow;
  assign status       = res.status;
  assign flow_packets = res.packets;
  assign flow_bytes   = res.bytes;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives packet headers into flow_counter_hash_chain_core, predicts each
// per-flow count in a scoreboard that keeps its own bucket and pool tables,
// and compares every result beat in order; flows are aimed at a few hot
// buckets so chains grow long and the overflow pool runs out
// ----------------------------------------------------------------------------
module testbench;
  import fchc_pkg::*;

  localparam int NBUCKET = 1021;
  localparam int NPOOL = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    bit [31:0] src;
    bit [31:0] dst;
    bit [15:0] sp;
    bit [15:0] dp;
  } flow_tuple_t;

  class flow_scoreboard;
    bit [31:0] bkt_src[NBUCKET], bkt_dst[NBUCKET], bkt_ports[NBUCKET];
    bit [31:0] bkt_pkts[NBUCKET], bkt_bytes[NBUCKET];
    bit [10:0] bkt_next[NBUCKET];
    bit [31:0] pl_src[NPOOL], pl_dst[NPOOL], pl_ports[NPOOL];
    bit [31:0] pl_pkts[NPOOL], pl_bytes[NPOOL];
    bit [10:0] pl_next[NPOOL];
    int unsigned pool_taken;
    bit [7:0] counted_proto;
    fchc_result_t pending_counts[$];
    int mismatches;

    function new();
      for (int i = 0; i < NBUCKET; i++) begin
        bkt_pkts[i] = 0; bkt_bytes[i] = 0; bkt_next[i] = 0;
      end
      for (int i = 0; i < NPOOL; i++) begin
        pl_pkts[i] = 0; pl_bytes[i] = 0; pl_next[i] = 0;
      end
      pool_taken = 0;
      counted_proto = RESET_PROTOCOL;
      mismatches = 0;
    endfunction

    function void note_packet(flow_tuple_t t, bit [7:0] proto, bit [15:0] len);
      bit [31:0] ports, sum;
      int unsigned b, lnk, last, steps, e;
      fchc_result_t r;
      if (proto != counted_proto) return;
      ports = {t.sp, t.dp};
      sum = t.src + t.dst + {16'd0, t.sp} + {16'd0, t.dp};
      b = sum % NBUCKET;
      if (bkt_pkts[b] == 0) begin
        bkt_src[b] = t.src; bkt_dst[b] = t.dst; bkt_ports[b] = ports;
        bkt_next[b] = 0; bkt_pkts[b] = 1; bkt_bytes[b] = len;
        r = '{1'b1, 1'b0, bkt_pkts[b], bkt_bytes[b]};
        pending_counts.push_back(r);
        return;
      end
      if (bkt_src[b] == t.src && bkt_dst[b] == t.dst && bkt_ports[b] == ports) begin
        bkt_pkts[b] += 1; bkt_bytes[b] += len;
        r = '{1'b0, 1'b0, bkt_pkts[b], bkt_bytes[b]};
        pending_counts.push_back(r);
        return;
      end
      lnk = bkt_next[b]; last = 0; steps = 0;
      while (lnk != 0 && lnk <= NPOOL && steps < NPOOL) begin
        e = lnk - 1;
        if (pl_src[e] == t.src && pl_dst[e] == t.dst && pl_ports[e] == ports) begin
          pl_pkts[e] += 1; pl_bytes[e] += len;
          r = '{1'b0, 1'b0, pl_pkts[e], pl_bytes[e]};
          pending_counts.push_back(r);
          return;
        end
        last = lnk; lnk = pl_next[e]; steps++;
      end
      if (pool_taken >= NPOOL) begin
        r = '{1'b0, 1'b1, 32'd0, 32'd0};
        pending_counts.push_back(r);
        return;
      end
      e = pool_taken;
      pl_src[e] = t.src; pl_dst[e] = t.dst; pl_ports[e] = ports;
      pl_pkts[e] = 1; pl_bytes[e] = len; pl_next[e] = 0;
      if (last == 0) bkt_next[b] = e + 1;
      else pl_next[last - 1] = e + 1;
      pool_taken = e + 1;
      r = '{1'b1, 1'b0, pl_pkts[e], pl_bytes[e]};
      pending_counts.push_back(r);
    endfunction

    function void check_result(fchc_result_t got);
      fchc_result_t want;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: nf=%0d st=%0d pk=%0d by=%0d",
                   got.new_flow, got.status, got.packets, got.bytes);
        return;
      end
      want = pending_counts.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp nf=%0d st=%0d pk=%0d by=%0d, got nf=%0d st=%0d pk=%0d by=%0d",
                   want.new_flow, want.status, want.packets, want.bytes,
                   got.new_flow, got.status, got.packets, got.bytes);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [31:0] source_address = '0, dest_address = '0;
  logic [15:0] source_port = '0, dest_port = '0;
  logic [7:0] protocol = '0;
  logic [15:0] packet_length = '0;
  logic empty;
  logic pop = 1'b0;
  logic new_flow, status;
  logic [31:0] flow_packets, flow_bytes;

  flow_scoreboard sb = new();
  flow_tuple_t known_flows[$];
  bit quiet_phase = 0;
  int idle_cycles = 0;

  flow_counter_hash_chain_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full),
    .source_address(source_address), .dest_address(dest_address),
    .source_port(source_port), .dest_port(dest_port),
    .protocol(protocol), .packet_length(packet_length),
    .empty(empty), .pop(pop), .new_flow(new_flow), .status(status),
    .flow_packets(flow_packets), .flow_bytes(flow_bytes)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic flow_tuple_t flow_in_bucket(int unsigned b);
    flow_tuple_t t;
    bit [31:0] sum;
    t.src = $urandom(); t.sp = $urandom(); t.dp = $urandom();
    sum = b + NBUCKET * $urandom_range(0, 4206600);
    t.dst = sum - t.src - {16'd0, t.sp} - {16'd0, t.dp};
    return t;
  endfunction

  task automatic send_packet(flow_tuple_t t, bit [7:0] proto, bit [15:0] len);
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk) push <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    source_address <= t.src; dest_address <= t.dst;
    source_port <= t.sp; dest_port <= t.dp;
    protocol <= proto; packet_length <= len;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    sb.note_packet(t, proto, len);
  endtask

  task automatic drain_and_write(bit [7:0] value);
    @(negedge clk) push <= 1'b0;
    while (sb.pending_counts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    @(negedge clk) begin
      cfg_we <= 1'b1; cfg_data <= value;
    end
    @(negedge clk) cfg_we <= 1'b0;
    sb.counted_proto = value;
  endtask

  task automatic random_packets(int count, int hot, int new_share);
    flow_tuple_t t;
    int r;
    bit [7:0] proto;
    for (int n = 0; n < count; n++) begin
      if (n % 300 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      proto = sb.counted_proto;
      if (r < 8) begin
        t = flow_in_bucket($urandom_range(0, NBUCKET - 1));
        proto = $urandom();
      end else if (r < 8 + new_share || known_flows.size() == 0) begin
        if ($urandom_range(0, 4) == 0) t = flow_in_bucket($urandom_range(0, NBUCKET - 1));
        else t = flow_in_bucket($urandom_range(0, hot - 1));
        known_flows.push_back(t);
      end else begin
        t = known_flows[$urandom_range(0, known_flows.size() - 1)];
      end
      send_packet(t, proto, $urandom());
    end
  endtask

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && pop && !empty)
      sb.check_result('{new_flow, status, flow_packets, flow_bytes});
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL flow_counter_hash_chain_core");
        $finish;
      end
    end
  end

  initial begin : result_side
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = gap_len();
      pop <= 1'b0;
      repeat (g) @(negedge clk);
      pop <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    flow_tuple_t t, a, b2, c;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed beats
    t = '{32'd0, 32'd0, 16'd0, 16'd0};
    send_packet(t, RESET_PROTOCOL, 16'd0);
    send_packet(t, RESET_PROTOCOL, 16'hffff);
    t = '{32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff};
    send_packet(t, RESET_PROTOCOL, 16'hffff);
    send_packet(t, 8'd17, 16'd100);
    send_packet(t, 8'hff, 16'd100);
    send_packet(t, RESET_PROTOCOL, 16'd1);
    a = flow_in_bucket(NBUCKET - 1);
    b2 = flow_in_bucket(NBUCKET - 1);
    c = flow_in_bucket(NBUCKET - 1);
    send_packet(a, RESET_PROTOCOL, 16'd64);
    send_packet(b2, RESET_PROTOCOL, 16'd1500);
    send_packet(c, RESET_PROTOCOL, 16'd40);
    send_packet(c, RESET_PROTOCOL, 16'd40);
    send_packet(b2, RESET_PROTOCOL, 16'd9000);
    send_packet(a, RESET_PROTOCOL, 16'd64);
    send_packet(c, 8'd0, 16'd40);
    known_flows.push_back(a);
    known_flows.push_back(b2);
    known_flows.push_back(c);

    drain_and_write(8'hff);
    send_packet(a, 8'hff, 16'd7);
    random_packets(100, 40, 60);
    drain_and_write(8'd0);
    send_packet(c, 8'd0, 16'hffff);
    random_packets(100, 40, 60);
    drain_and_write(RESET_PROTOCOL);
    random_packets(1650, 40, 70);

    @(negedge clk) push <= 1'b0;
    while (sb.pending_counts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_counts.size() == 0) begin
      $display("PASS flow_counter_hash_chain_core");
    end else begin
      $display("FAIL flow_counter_hash_chain_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fchc_pkg.sv
hw/rtl/fchc_front.sv
hw/rtl/fchc_back.sv
hw/rtl/flow_counter_hash_chain_core.sv
dv/testbench.sv
